### design/two_qubit_gate_apply_defines.svh
`ifndef TWO_QUBIT_GATE_APPLY_DEFINES_SVH
`define TWO_QUBIT_GATE_APPLY_DEFINES_SVH

// Both macros expect clk_i and rst_ni in scope and are disabled while reset is asserted.

// Labeled assertion of a property checked at every rising clock edge.
`define TQGA_ASSERT(label, body, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (body)) \
    else $error(msg);

// Labeled assertion that a trigger is followed, in the next cycle, by a sequence.
`define TQGA_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### design/tqga_pkg.sv
package tqga_pkg;

  // Store geometry.
  localparam int MaxQubits  = 10;
  localparam int StoreDepth = 1 << MaxQubits;
  localparam int AddrW      = MaxQubits;

  // Field widths.
  localparam int CfgQW     = 4;
  localparam int QubitW    = $clog2(MaxQubits + 1);
  localparam int CmpW      = (CfgQW > QubitW) ? CfgQW : QubitW;
  localparam int IdxFieldW = 10;
  localparam int AmpW      = 16;
  localparam int WordW     = 2 * AmpW;
  localparam int CoefW     = 8;
  localparam int CoefPairW = 2 * CoefW;
  localparam int NumTerms  = 4;
  localparam int TermIdxW  = $clog2(NumTerms);
  localparam int GateRowW  = NumTerms * CoefPairW;

  // Datapath widths: Q2.6 x Q2.14 products, four-term sums.
  localparam int ProdW      = CoefW + AmpW;
  localparam int TermW      = ProdW + 1;
  localparam int SumW       = TermW + TermIdxW;
  localparam int RoundShift = 6;
  localparam int RoundBias  = 1 << (RoundShift - 1);
  localparam int RoundW     = SumW + 1 - RoundShift;

  localparam logic [AmpW-1:0] AmpMax = {1'b0, {(AmpW - 1){1'b1}}};
  localparam logic [AmpW-1:0] AmpMin = {1'b1, {(AmpW - 1){1'b0}}};
  localparam logic signed [RoundW-1:0] RoundHi = RoundW'($signed(AmpMax));
  localparam logic signed [RoundW-1:0] RoundLo = RoundW'($signed(AmpMin));

  // Stream beat layout.
  localparam int InDataW  = ((IdxFieldW + 2 * AmpW + 7) / 8) * 8;
  localparam int OutDataW = ((2 * AmpW + 7) / 8) * 8;

  // Configuration port.
  localparam int ApbAddrW  = 6;
  localparam int ApbDataW  = 64;
  localparam int ApbIdxLsb = 3;
  localparam int ApbIdxW   = ApbAddrW - ApbIdxLsb;

  // Register reset values; the gate resets to CNOT.
  localparam logic [CfgQW-1:0]    NumQubitsRst   = CfgQW'(10);
  localparam logic [CfgQW-1:0]    FirstQubitRst  = CfgQW'(1);
  localparam logic [CfgQW-1:0]    SecondQubitRst = CfgQW'(2);
  localparam logic [GateRowW-1:0] GateRow0Rst    = 64'd64;
  localparam logic [GateRowW-1:0] GateRow1Rst    = 64'd4194304;
  localparam logic [GateRowW-1:0] GateRow2Rst    = 64'd18014398509481984;
  localparam logic [GateRowW-1:0] GateRow3Rst    = 64'd274877906944;

  // Outstanding compute results the output side can hold.
  localparam int PendW   = 2;
  localparam int PendMax = 2;

  typedef enum logic [ApbIdxW-1:0] {
    RegNumQubits   = 3'd0,
    RegFirstQubit  = 3'd1,
    RegSecondQubit = 3'd2,
    RegGateRow0    = 3'd3,
    RegGateRow1    = 3'd4,
    RegGateRow2    = 3'd5,
    RegGateRow3    = 3'd6
  } reg_idx_e;

  typedef enum logic {
    FuncLoad    = 1'b0,
    FuncCompute = 1'b1
  } func_e;

  // Tag that travels with each amplitude read into the MAC.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } term_ctl_t;

  typedef struct packed {
    logic signed [SumW-1:0] re;
    logic signed [SumW-1:0] im;
  } cplx_sum_t;

  // Round to 14 fraction bits (ties upward) and clip; MSB of the result is the clip flag.
  function automatic logic [AmpW:0] round_sat(input logic signed [SumW-1:0] sum);
    logic signed [SumW:0]     biased;
    logic signed [RoundW-1:0] q;
    logic [AmpW:0]            r;
    biased = (SumW + 1)'(sum) + (SumW + 1)'(RoundBias);
    q      = biased[SumW:RoundShift];
    if (q > RoundHi) begin
      r = {1'b1, AmpMax};
    end else if (q < RoundLo) begin
      r = {1'b1, AmpMin};
    end else begin
      r = {1'b0, q[AmpW-1:0]};
    end
    return r;
  endfunction

endpackage

### design/two_qubit_gate_apply.sv
// Load beat: the amplitude is written into the store at the accept edge.
// Compute beat: accept reads term 0, then three more reads of the single-port amplitude
// store follow, and the input side takes no new beat until they are done.
// Result path: store read, product registers, result slot, then the output register.
// Reset clears the control and loads the CNOT gate, ten qubits, qubits one and two;
// store contents stay undefined until loaded, with no clearing pass.
module two_qubit_gate_apply (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] amp_index, [25:10] load_real, [41:26] load_imag, [47:42] zero
  input  logic [tqga_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] func
  input  logic                              s_axis_tuser,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] out_real, [31:16] out_imag
  output logic [tqga_pkg::OutDataW-1:0]     m_axis_tdata,
  // [0] saturated
  output logic                              m_axis_tuser,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tqga_pkg::ApbAddrW-1:0]     paddr,
  input  logic [tqga_pkg::ApbDataW-1:0]     pwdata,
  output logic [tqga_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  typedef enum logic {
    SeqIdle,
    SeqRead
  } seq_e;

  localparam logic [tqga_pkg::TermIdxW-1:0] TermLast = tqga_pkg::TermIdxW'(tqga_pkg::NumTerms - 1);

  // Configuration registers.
  logic [tqga_pkg::CfgQW-1:0]    nq_q, fq_q, sq_q;
  logic [tqga_pkg::GateRowW-1:0] gate0_q, gate1_q, gate2_q, gate3_q;
  logic                          cfg_we;
  tqga_pkg::reg_idx_e            cfg_idx;

  // Index geometry.
  logic [tqga_pkg::CmpW-1:0]  n_eff, k1, k2, s1, s2;
  logic [tqga_pkg::AddrW-1:0] idx_mask, m1, m2;

  // Input beat fields.
  logic [tqga_pkg::AddrW-1:0] in_idx;
  logic [tqga_pkg::AmpW-1:0]  in_re, in_im;
  logic                       in_fire, in_compute;

  // Sequencer.
  seq_e                          state_q;
  logic [tqga_pkg::TermIdxW-1:0] term_q;
  logic [tqga_pkg::AddrW-1:0]    i_q;
  logic [tqga_pkg::GateRowW-1:0] row_q, row_sel;
  logic [1:0]                    row_code;
  tqga_pkg::term_ctl_t           tag_d, tag_q;
  logic [tqga_pkg::CoefPairW-1:0] coef_d, coef_q;

  // Store port.
  logic                       ram_en, ram_we;
  logic [tqga_pkg::AddrW-1:0] ram_addr;
  logic [tqga_pkg::WordW-1:0] ram_wdata, ram_rdata;

  // Result path.
  logic                       res_valid, res_pop;
  tqga_pkg::cplx_sum_t        res;
  logic [tqga_pkg::AmpW:0]    rnd_re, rnd_im;
  logic                       out_valid_d, out_valid_q;
  logic [tqga_pkg::WordW-1:0] out_data_q;
  logic                       out_sat_q;
  logic [tqga_pkg::PendW-1:0] pend_d, pend_q;
  logic                       out_fire;

  // Address of term c: the two gate-qubit bits of i forced to the bits of c.
  function automatic logic [tqga_pkg::AddrW-1:0] term_addr(
    input logic [tqga_pkg::AddrW-1:0]    i,
    input logic [tqga_pkg::AddrW-1:0]    mk1,
    input logic [tqga_pkg::AddrW-1:0]    mk2,
    input logic [tqga_pkg::TermIdxW-1:0] c
  );
    logic [tqga_pkg::AddrW-1:0] t;
    t = c[1] ? (i | mk1) : (i & ~mk1);
    t = c[0] ? (t | mk2) : (t & ~mk2);
    return t;
  endfunction

  // Configuration writes and reads.
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = tqga_pkg::reg_idx_e'(paddr[tqga_pkg::ApbAddrW-1:tqga_pkg::ApbIdxLsb]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nq_q    <= tqga_pkg::NumQubitsRst;
      fq_q    <= tqga_pkg::FirstQubitRst;
      sq_q    <= tqga_pkg::SecondQubitRst;
      gate0_q <= tqga_pkg::GateRow0Rst;
      gate1_q <= tqga_pkg::GateRow1Rst;
      gate2_q <= tqga_pkg::GateRow2Rst;
      gate3_q <= tqga_pkg::GateRow3Rst;
    end else if (cfg_we) begin
      case (cfg_idx)
        tqga_pkg::RegNumQubits:   nq_q    <= pwdata[tqga_pkg::CfgQW-1:0];
        tqga_pkg::RegFirstQubit:  fq_q    <= pwdata[tqga_pkg::CfgQW-1:0];
        tqga_pkg::RegSecondQubit: sq_q    <= pwdata[tqga_pkg::CfgQW-1:0];
        tqga_pkg::RegGateRow0:    gate0_q <= pwdata[tqga_pkg::GateRowW-1:0];
        tqga_pkg::RegGateRow1:    gate1_q <= pwdata[tqga_pkg::GateRowW-1:0];
        tqga_pkg::RegGateRow2:    gate2_q <= pwdata[tqga_pkg::GateRowW-1:0];
        tqga_pkg::RegGateRow3:    gate3_q <= pwdata[tqga_pkg::GateRowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tqga_pkg::RegNumQubits:   prdata = tqga_pkg::ApbDataW'(nq_q);
      tqga_pkg::RegFirstQubit:  prdata = tqga_pkg::ApbDataW'(fq_q);
      tqga_pkg::RegSecondQubit: prdata = tqga_pkg::ApbDataW'(sq_q);
      tqga_pkg::RegGateRow0:    prdata = tqga_pkg::ApbDataW'(gate0_q);
      tqga_pkg::RegGateRow1:    prdata = tqga_pkg::ApbDataW'(gate1_q);
      tqga_pkg::RegGateRow2:    prdata = tqga_pkg::ApbDataW'(gate2_q);
      tqga_pkg::RegGateRow3:    prdata = tqga_pkg::ApbDataW'(gate3_q);
      default:                  prdata = '0;
    endcase
  end

  // Clamp the qubit count and the gate qubits, then derive the index masks.
  always_comb begin
    if (nq_q == '0) begin
      n_eff = tqga_pkg::CmpW'(1);
    end else if (tqga_pkg::CmpW'(nq_q) > tqga_pkg::CmpW'(tqga_pkg::MaxQubits)) begin
      n_eff = tqga_pkg::CmpW'(tqga_pkg::MaxQubits);
    end else begin
      n_eff = tqga_pkg::CmpW'(nq_q);
    end
    if (fq_q == '0) begin
      k1 = tqga_pkg::CmpW'(1);
    end else if (tqga_pkg::CmpW'(fq_q) > n_eff) begin
      k1 = n_eff;
    end else begin
      k1 = tqga_pkg::CmpW'(fq_q);
    end
    if (sq_q == '0) begin
      k2 = tqga_pkg::CmpW'(1);
    end else if (tqga_pkg::CmpW'(sq_q) > n_eff) begin
      k2 = n_eff;
    end else begin
      k2 = tqga_pkg::CmpW'(sq_q);
    end
    s1       = n_eff - k1;
    s2       = n_eff - k2;
    m1       = tqga_pkg::AddrW'(1) << s1;
    m2       = tqga_pkg::AddrW'(1) << s2;
    idx_mask = ~({tqga_pkg::AddrW{1'b1}} << n_eff);
  end

  // Input beat.
  assign in_idx = tqga_pkg::AddrW'(s_axis_tdata[tqga_pkg::IdxFieldW-1:0]) & idx_mask;
  assign in_re  = s_axis_tdata[tqga_pkg::IdxFieldW +: tqga_pkg::AmpW];
  assign in_im  = s_axis_tdata[tqga_pkg::IdxFieldW + tqga_pkg::AmpW +: tqga_pkg::AmpW];

  assign s_axis_tready = (state_q == SeqIdle) && (pend_q < tqga_pkg::PendW'(tqga_pkg::PendMax));
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign in_compute    = in_fire & (s_axis_tuser == tqga_pkg::FuncCompute);

  // Gate row picked by the two gate-qubit bits of the index.
  assign row_code = {|(in_idx & m1), |(in_idx & m2)};
  always_comb begin
    case (row_code)
      2'd0:    row_sel = gate0_q;
      2'd1:    row_sel = gate1_q;
      2'd2:    row_sel = gate2_q;
      2'd3:    row_sel = gate3_q;
      default: row_sel = gate0_q;
    endcase
  end

  // Store port: loads write at accept; computes read term 0 at accept, then one per cycle.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = i_q;
    ram_wdata = {in_im, in_re};
    tag_d     = '0;
    coef_d    = row_q[{term_q, 4'b0000} +: tqga_pkg::CoefPairW];
    if (in_fire) begin
      ram_en = 1'b1;
      if (in_compute) begin
        ram_addr    = term_addr(in_idx, m1, m2, '0);
        tag_d.valid = 1'b1;
        tag_d.first = 1'b1;
        coef_d      = row_sel[tqga_pkg::CoefPairW-1:0];
      end else begin
        ram_we   = 1'b1;
        ram_addr = in_idx;
      end
    end else if (state_q == SeqRead) begin
      ram_en      = 1'b1;
      ram_addr    = term_addr(i_q, m1, m2, term_q);
      tag_d.valid = 1'b1;
      tag_d.last  = (term_q == TermLast);
    end
  end

  // Sequencer state and the read tag that lines up with the store's read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
      term_q  <= '0;
      tag_q   <= '0;
    end else begin
      tag_q <= tag_d;
      case (state_q)
        SeqIdle: begin
          if (in_compute) begin
            state_q <= SeqRead;
            term_q  <= tqga_pkg::TermIdxW'(1);
          end
        end
        SeqRead: begin
          term_q <= term_q + tqga_pkg::TermIdxW'(1);
          if (term_q == TermLast) begin
            state_q <= SeqIdle;
          end
        end
        default: state_q <= SeqIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
    if (in_compute) begin
      i_q   <= in_idx;
      row_q <= row_sel;
    end
  end

  tqga_ram #(
    .Width (tqga_pkg::WordW),
    .Depth (tqga_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  tqga_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_i      (tag_q),
    .coef_i      (coef_q),
    .amp_i       (ram_rdata),
    .pop_i       (res_pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register, refilled from the result slot whenever it empties.
  assign rnd_re      = tqga_pkg::round_sat(res.re);
  assign rnd_im      = tqga_pkg::round_sat(res.im);
  assign out_fire    = out_valid_q & m_axis_tready;
  assign res_pop     = res_valid & (~out_valid_q | m_axis_tready);
  assign out_valid_d = res_pop | (out_valid_q & ~m_axis_tready);

  // Compute beats in flight, bounded by the result slot plus the output register.
  always_comb begin
    pend_d = pend_q;
    if (in_compute && !out_fire) begin
      pend_d = pend_q + tqga_pkg::PendW'(1);
    end else if (!in_compute && out_fire) begin
      pend_d = pend_q - tqga_pkg::PendW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_pop) begin
      out_data_q <= {rnd_im[tqga_pkg::AmpW-1:0], rnd_re[tqga_pkg::AmpW-1:0]};
      out_sat_q  <= rnd_re[tqga_pkg::AmpW] | rnd_im[tqga_pkg::AmpW];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tqga_pkg::OutDataW'(out_data_q);
  assign m_axis_tuser  = out_sat_q;

endmodule

### design/tqga_ram.sv
module tqga_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port: write or registered read, one access per cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tqga_mac.sv
module tqga_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tqga_pkg::term_ctl_t                term_i,
  input  logic [tqga_pkg::CoefPairW-1:0]     coef_i,
  input  logic [tqga_pkg::WordW-1:0]         amp_i,
  input  logic                               pop_i,
  output logic                               res_valid_o,
  output tqga_pkg::cplx_sum_t                res_o
);

  logic signed [tqga_pkg::CoefW-1:0] gr, gi;
  logic signed [tqga_pkg::AmpW-1:0]  ar, ai;

  logic signed [tqga_pkg::ProdW-1:0] prr_d, pii_d, pri_d, pir_d;
  logic signed [tqga_pkg::ProdW-1:0] prr_q, pii_q, pri_q, pir_q;
  tqga_pkg::term_ctl_t               p_ctl_q;

  logic signed [tqga_pkg::TermW-1:0] term_re, term_im;
  logic signed [tqga_pkg::SumW-1:0]  base_re, base_im;
  logic signed [tqga_pkg::SumW-1:0]  sum_re, sum_im;
  logic signed [tqga_pkg::SumW-1:0]  acc_re_q, acc_im_q;

  logic                res_valid_d, res_valid_q;
  logic                land;
  tqga_pkg::cplx_sum_t res_q;

  // Unpack the gate entry and the amplitude word.
  assign gr = coef_i[tqga_pkg::CoefW-1:0];
  assign gi = coef_i[tqga_pkg::CoefPairW-1:tqga_pkg::CoefW];
  assign ar = amp_i[tqga_pkg::AmpW-1:0];
  assign ai = amp_i[tqga_pkg::WordW-1:tqga_pkg::AmpW];

  // Four real partial products of one complex multiply.
  assign prr_d = tqga_pkg::ProdW'(gr) * tqga_pkg::ProdW'(ar);
  assign pii_d = tqga_pkg::ProdW'(gi) * tqga_pkg::ProdW'(ai);
  assign pri_d = tqga_pkg::ProdW'(gr) * tqga_pkg::ProdW'(ai);
  assign pir_d = tqga_pkg::ProdW'(gi) * tqga_pkg::ProdW'(ar);

  // Combine the products and add to the running sum; the first term restarts it.
  assign term_re = tqga_pkg::TermW'(prr_q) - tqga_pkg::TermW'(pii_q);
  assign term_im = tqga_pkg::TermW'(pri_q) + tqga_pkg::TermW'(pir_q);
  assign base_re = p_ctl_q.first ? '0 : acc_re_q;
  assign base_im = p_ctl_q.first ? '0 : acc_im_q;
  assign sum_re  = base_re + tqga_pkg::SumW'(term_re);
  assign sum_im  = base_im + tqga_pkg::SumW'(term_im);

  // The last term drops its sum into the result slot, which holds until popped.
  assign land        = p_ctl_q.valid & p_ctl_q.last;
  assign res_valid_d = land | (res_valid_q & ~pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_ctl_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      p_ctl_q     <= term_i;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (term_i.valid) begin
      prr_q <= prr_d;
      pii_q <= pii_d;
      pri_q <= pri_d;
      pir_q <= pir_d;
    end
    if (p_ctl_q.valid) begin
      acc_re_q <= sum_re;
      acc_im_q <= sum_im;
    end
    if (land) begin
      res_q.re <= sum_re;
      res_q.im <= sum_im;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### design/tqga_checker.sv
`include "two_qubit_gate_apply_defines.svh"

module tqga_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tqga_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  logic [tqga_pkg::AmpW-1:0]   out_re, out_im;
  logic [tqga_pkg::OutDataW:0] out_beat;
  logic                        out_stall, in_compute, sat_shown, re_clip, im_clip;

  // Port views used by the properties below.
  assign out_re     = m_axis_tdata[tqga_pkg::AmpW-1:0];
  assign out_im     = m_axis_tdata[tqga_pkg::WordW-1:tqga_pkg::AmpW];
  assign out_beat   = {m_axis_tuser, m_axis_tdata};
  assign out_stall  = m_axis_tvalid & ~m_axis_tready;
  assign in_compute = s_axis_tvalid & s_axis_tready & (s_axis_tuser == tqga_pkg::FuncCompute);
  assign sat_shown  = m_axis_tvalid & m_axis_tuser;
  assign re_clip    = (out_re == tqga_pkg::AmpMax) | (out_re == tqga_pkg::AmpMin);
  assign im_clip    = (out_im == tqga_pkg::AmpMax) | (out_im == tqga_pkg::AmpMin);

  // A stalled result beat keeps its valid and payload.
  `TQGA_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_beat), "stalled beat changed")

  // A compute beat holds the store port for three more reads.
  `TQGA_ASSERT_NEXT(a_compute_busy, in_compute, !s_axis_tready [*3], "input taken during reads")

  // A clipped result has at least one part at a range limit.
  `TQGA_ASSERT(a_sat_limit, sat_shown |-> re_clip || im_clip, "saturated without a clipped part")

endmodule

bind two_qubit_gate_apply tqga_checker u_tqga_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/two_qubit_gate_apply_test.sv
`timescale 1ns / 1ps

module two_qubit_gate_apply_test;
  import tqga_pkg::*;

  localparam int HalfPeriod   = 6;
  localparam int ResetCycles  = 4;
  // Leave margin for the result path and the output stage.
  localparam int SettleCycles = 16;
  localparam int ShownErrors  = 10;
  localparam int PhaseBeats   = 235;
  localparam int NumPhases    = 8;

  typedef struct packed {
    logic [AmpW-1:0] re;
    logic [AmpW-1:0] im;
    logic            sat;
  } gated_amp_t;

  // The four store addresses a compute beat reads, and the gate row it uses.
  typedef struct packed {
    logic [3:0][IdxFieldW-1:0] addr;
    logic [1:0]                row;
  } gate_taps_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ApbAddrW-1:0]  paddr = '0;
  logic [ApbDataW-1:0]  pwdata = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  // Shadow copy of the block's store and registers.
  logic [WordW-1:0]     amp_mem [StoreDepth];
  bit                   amp_loaded [StoreDepth];
  logic [CfgQW-1:0]     qubit_count_reg;
  logic [CfgQW-1:0]     first_qubit_reg;
  logic [CfgQW-1:0]     second_qubit_reg;
  logic [GateRowW-1:0]  gate_row_reg [NumTerms];

  gated_amp_t           pending_amps [$];
  int                   mismatch_count = 0;
  int                   beats_sent = 0;
  int                   stall_left = 0;
  bit                   no_idle = 1'b0;

  two_qubit_gate_apply DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #HalfPeriod clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= ShownErrors) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  // Idle length in cycles: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic int unsigned active_qubits();
    if (qubit_count_reg == 0) begin
      return 1;
    end else if (qubit_count_reg > MaxQubits) begin
      return MaxQubits;
    end
    return qubit_count_reg;
  endfunction

  function automatic gate_taps_t gate_taps(input logic [IdxFieldW-1:0] raw);
    int unsigned n, mask, i, k1, k2, s1, s2, m1, m2;
    gate_taps_t t;
    n    = active_qubits();
    mask = (1 << n) - 1;
    i    = raw & mask;
    // Gate qubits are clamped into 1..n; bit 1 is the most significant index bit.
    k1 = (first_qubit_reg == 0) ? 1 : (first_qubit_reg > n) ? n : first_qubit_reg;
    k2 = (second_qubit_reg == 0) ? 1 : (second_qubit_reg > n) ? n : second_qubit_reg;
    s1 = n - k1;
    s2 = n - k2;
    m1 = 1 << s1;
    m2 = 1 << s2;
    t.addr[0] = IdxFieldW'((i & ~m1 & ~m2) & mask);
    t.addr[1] = IdxFieldW'(((i & ~m1) | m2) & mask);
    t.addr[2] = IdxFieldW'(((i | m1) & ~m2) & mask);
    t.addr[3] = IdxFieldW'((i | m1 | m2) & mask);
    // With equal qubits both bits are the same, so the row lands on 0 or 3.
    t.row = 2'((((i & m1) >> s1) << 1) + ((i & m2) >> s2));
    return t;
  endfunction

  // Round a 20-fraction-bit sum to Q2.14 (ties upward) and clip.
  function automatic logic [AmpW-1:0] clip_q14(input longint acc, inout bit clipped);
    longint q;
    q = (acc + RoundBias) >>> RoundShift;
    if (q > 32767) begin
      clipped = 1'b1;
      q = 32767;
    end else if (q < -32768) begin
      clipped = 1'b1;
      q = -32768;
    end
    return q[AmpW-1:0];
  endfunction

  function automatic gated_amp_t gated_amplitude(input logic [IdxFieldW-1:0] raw);
    gate_taps_t          t;
    logic [GateRowW-1:0] coefs;
    logic [WordW-1:0]    w;
    longint              acc_re, acc_im, gr, gi, ar, ai;
    bit                  clipped;
    gated_amp_t          r;
    t       = gate_taps(raw);
    coefs   = gate_row_reg[t.row];
    acc_re  = 0;
    acc_im  = 0;
    clipped = 1'b0;
    for (int c = 0; c < NumTerms; c++) begin
      gr = longint'($signed(coefs[CoefPairW*c +: CoefW]));
      gi = longint'($signed(coefs[CoefPairW*c + CoefW +: CoefW]));
      w  = amp_mem[t.addr[c]];
      ar = longint'($signed(w[AmpW-1:0]));
      ai = longint'($signed(w[WordW-1:AmpW]));
      acc_re += gr * ar - gi * ai;
      acc_im += gr * ai + gi * ar;
    end
    r.re  = clip_q14(acc_re, clipped);
    r.im  = clip_q14(acc_im, clipped);
    r.sat = clipped;
    return r;
  endfunction

  function automatic logic [AmpW-1:0] rand_amp();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return AmpW'($urandom_range(0, 4000) - 2000);
      default: return AmpW'($urandom);
    endcase
  endfunction

  // Mix of full-range, near-unit and zero coefficients.
  function automatic logic [GateRowW-1:0] rand_gate_row();
    logic [GateRowW-1:0] v;
    for (int b = 0; b < GateRowW / CoefW; b++) begin
      case ($urandom_range(0, 3))
        0:       v[CoefW*b +: CoefW] = CoefW'($urandom);
        1:       v[CoefW*b +: CoefW] = CoefW'($urandom_range(0, 128) - 64);
        2:       v[CoefW*b +: CoefW] = 8'h40;
        default: v[CoefW*b +: CoefW] = '0;
      endcase
    end
    return v;
  endfunction

  // Send one beat on the input stream and update the shadow state when it is taken.
  task automatic send_beat(input func_e f, input logic [IdxFieldW-1:0] idx,
                           input logic [AmpW-1:0] re, input logic [AmpW-1:0] im);
    int                   gap;
    logic [IdxFieldW-1:0] addr;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= InDataW'({im, re, idx});
    do @(posedge clk_i); while (!s_axis_tready);
    if (f == FuncLoad) begin
      addr = idx & IdxFieldW'((1 << active_qubits()) - 1);
      amp_mem[addr]    = {im, re};
      amp_loaded[addr] = 1'b1;
    end else begin
      pending_amps.push_back(gated_amplitude(idx));
    end
    beats_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_amps.size() != 0);
  endtask

  // Compute at an index, first loading any of its four taps never written.
  task automatic compute_at(input logic [IdxFieldW-1:0] raw,
                            input logic [AmpW-1:0] re, input logic [AmpW-1:0] im);
    gate_taps_t           t;
    logic [IdxFieldW-1:0] high_bits;
    t = gate_taps(raw);
    high_bits = ~IdxFieldW'((1 << active_qubits()) - 1);
    for (int c = 0; c < NumTerms; c++) begin
      if (!amp_loaded[t.addr[c]]) begin
        send_beat(FuncLoad, t.addr[c] | (IdxFieldW'($urandom) & high_bits),
                  rand_amp(), rand_amp());
      end
    end
    send_beat(FuncCompute, raw, re, im);
  endtask

  // Register write; the block must be idle, so drain results first.
  task automatic write_reg(input reg_idx_e r, input logic [ApbDataW-1:0] v);
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(r) << ApbIdxLsb;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (r)
      RegNumQubits:   qubit_count_reg  = v[CfgQW-1:0];
      RegFirstQubit:  first_qubit_reg  = v[CfgQW-1:0];
      RegSecondQubit: second_qubit_reg = v[CfgQW-1:0];
      RegGateRow0:    gate_row_reg[0]  = v;
      RegGateRow1:    gate_row_reg[1]  = v;
      RegGateRow2:    gate_row_reg[2]  = v;
      RegGateRow3:    gate_row_reg[3]  = v;
      default: ;
    endcase
  endtask

  task automatic read_reg(input reg_idx_e r, output logic [ApbDataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(r) << ApbIdxLsb;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    v = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_qubits(input logic [CfgQW-1:0] n, input logic [CfgQW-1:0] q1,
                            input logic [CfgQW-1:0] q2);
    write_reg(RegNumQubits, ApbDataW'(n));
    write_reg(RegFirstQubit, ApbDataW'(q1));
    write_reg(RegSecondQubit, ApbDataW'(q2));
  endtask

  task automatic set_all_rows(input logic [GateRowW-1:0] v);
    for (int k = 0; k < NumTerms; k++) begin
      write_reg(reg_idx_e'(int'(RegGateRow0) + k), v);
    end
  endtask

  // Reset configuration: ten qubits, CNOT on qubits one and two.
  task automatic test_cnot_defaults();
    send_beat(FuncLoad, 10'd0,   16'h7fff, 16'h8000);
    send_beat(FuncLoad, 10'd256, 16'h8000, 16'h7fff);
    send_beat(FuncLoad, 10'd512, 16'h0001, 16'hffff);
    send_beat(FuncLoad, 10'd768, 16'h1234, 16'h0000);
    // Each gate row is used, row three twice; rows two and three swap their amplitudes.
    compute_at(10'd0,   16'h0000, 16'h0000);
    compute_at(10'd256, 16'hffff, 16'hffff);
    compute_at(10'd512, 16'h8000, 16'h7fff);
    compute_at(10'd768, 16'h5555, 16'haaaa);
    compute_at(10'd1023, 16'h0000, 16'hffff);
  endtask

  // Out-of-range qubit settings, equal qubits and saturating gates.
  task automatic test_clamped_config();
    // Zero qubits acts as one, and both gate qubits collapse onto the same bit.
    set_qubits(4'd0, 4'd0, 4'd15);
    compute_at(10'h3ff, 16'h0000, 16'h0000);
    compute_at(10'h3fe, 16'hffff, 16'hffff);
    // Too many qubits acts as the maximum; qubit 15 clamps to the last bit.
    set_qubits(4'd15, 4'd0, 4'd15);
    set_all_rows({GateRowW / CoefW{8'h80}});
    compute_at(10'd0, 16'h0000, 16'h0000);
    compute_at(10'd1023, 16'hffff, 16'hffff);
    set_all_rows({GateRowW / CoefW{8'h7f}});
    compute_at(10'd0, 16'h0000, 16'h0000);
    compute_at(10'd511, 16'h0000, 16'h0000);
  endtask

  task automatic test_register_readback();
    logic [ApbDataW-1:0] wr_val, rd_val;
    for (int k = 0; k < 7; k++) begin
      if (k < int'(RegGateRow0)) begin
        wr_val = ApbDataW'($urandom_range(0, 15));
      end else begin
        wr_val = {$urandom, $urandom};
      end
      write_reg(reg_idx_e'(k), wr_val);
      read_reg(reg_idx_e'(k), rd_val);
      if (rd_val !== wr_val) begin
        flag_error($sformatf("register %0d read %h, wrote %h", k, rd_val, wr_val));
      end
    end
  endtask

  // Random phases, each under its own register setting.
  task automatic test_random_traffic();
    int                   phase_start;
    logic [CfgQW-1:0]     n, q1, q2;
    logic [IdxFieldW-1:0] idx;
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       begin n = 4'd10; q1 = 4'd1;  q2 = 4'd10; end
        1:       begin n = 4'd1;  q1 = 4'd1;  q2 = 4'd1;  end
        2:       begin n = 4'd2;  q1 = 4'd2;  q2 = 4'd2;  end
        3:       begin n = 4'd15; q1 = 4'd0;  q2 = 4'd15; end
        default: begin
          n  = CfgQW'($urandom_range(0, 15));
          q1 = CfgQW'($urandom_range(0, 15));
          q2 = CfgQW'($urandom_range(0, 15));
        end
      endcase
      set_qubits(n, q1, q2);
      for (int k = 0; k < NumTerms; k++) begin
        write_reg(reg_idx_e'(int'(RegGateRow0) + k), rand_gate_row());
      end
      if (phase == 4) begin
        write_reg(RegGateRow0, '0);
        write_reg(RegGateRow3, '1);
      end
      // One phase runs back to back with no idling on either side.
      no_idle = (phase == 3);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PhaseBeats) begin
        idx = IdxFieldW'($urandom);
        if ($urandom_range(0, 99) < 30) begin
          send_beat(FuncLoad, idx, rand_amp(), rand_amp());
        end else begin
          compute_at(idx, AmpW'($urandom), AmpW'($urandom));
        end
        if (phase == 5 && beats_sent - phase_start == PhaseBeats / 2) begin
          wait_results();
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Check each result beat against the oldest prediction; stall the output at random.
  always @(posedge clk_i) begin : result_check
    gated_amp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_amps.size() == 0) begin
          flag_error($sformatf("result beat %h with nothing expected", m_axis_tdata));
        end else begin
          want = pending_amps.pop_front();
          if (m_axis_tdata[AmpW-1:0] !== want.re) begin
            flag_error($sformatf("out_real %h, expected %h",
                                 m_axis_tdata[AmpW-1:0], want.re));
          end
          if (m_axis_tdata[WordW-1:AmpW] !== want.im) begin
            flag_error($sformatf("out_imag %h, expected %h",
                                 m_axis_tdata[WordW-1:AmpW], want.im));
          end
          if (m_axis_tuser !== want.sat) begin
            flag_error($sformatf("saturated %b, expected %b", m_axis_tuser, want.sat));
          end
        end
      end
      if (stall_left == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int guard;
    qubit_count_reg  = NumQubitsRst;
    first_qubit_reg  = FirstQubitRst;
    second_qubit_reg = SecondQubitRst;
    gate_row_reg[0]  = GateRow0Rst;
    gate_row_reg[1]  = GateRow1Rst;
    gate_row_reg[2]  = GateRow2Rst;
    gate_row_reg[3]  = GateRow3Rst;
    for (int a = 0; a < StoreDepth; a++) begin
      amp_loaded[a] = 1'b0;
      amp_mem[a]    = '0;
    end
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cnot_defaults();
    test_clamped_config();
    test_register_readback();
    test_random_traffic();

    // Drain the remaining results, then give the block time to misbehave.
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_amps.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_amps.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_amps.size()));
    end
    if (mismatch_count == 0) begin
      $display("[two_qubit_gate_apply] OK");
    end else begin
      $display("[two_qubit_gate_apply] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20000000;
    $display("[two_qubit_gate_apply] ERROR");
    $finish;
  end

endmodule
